// ----- rtl/core/ckpb_pkg.sv -----
// Shared types, formats and constants of the chroma key pixel blend unit.
package ckpb_pkg;

  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CHROMA_W   = 9;
  localparam int unsigned TOL_W      = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned NUM_W      = 28;
  localparam int unsigned PROD_W     = 30;
  localparam int unsigned RECIP_W    = 29;
  localparam logic [RECIP_W-1:0] RECIP_1E6 = 29'd281474977;
  localparam int unsigned RECIP_SHIFT = 48;

  localparam int unsigned DIFF_W     = CHROMA_W + 1;
  localparam int unsigned SQ_W       = 19;
  localparam int unsigned RAD_W      = SQ_W + 2 * FRAC_BITS;
  localparam int unsigned ROOT_W     = (RAD_W + 1) / 2;
  localparam int unsigned RAD_PAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned DIST_W     = ROOT_W;
  localparam int unsigned CMP_W      = (DIST_W > TOL_W) ? DIST_W : TOL_W;

  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned KEEP_W     = QUOT_W + 1;
  localparam logic [KEEP_W-1:0] KEEP_ONE = KEEP_W'(1 << QUOT_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_CB  = 2'd0,
    REG_KEY_CR  = 2'd1,
    REG_TOL_LOW = 2'd2,
    REG_TOL_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KEEP_ZERO = 2'd0,
    KEEP_RAMP = 2'd1,
    KEEP_FULL = 2'd2
  } keep_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] fg_red;
    logic [PIX_W-1:0] fg_green;
    logic [PIX_W-1:0] fg_blue;
    logic [PIX_W-1:0] bg_red;
    logic [PIX_W-1:0] bg_green;
    logic [PIX_W-1:0] bg_blue;
    logic             last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             out_last;
  } pix_out_t;

  typedef struct packed {
    logic [CHROMA_W-1:0] key_blue_chroma;
    logic [CHROMA_W-1:0] key_red_chroma;
    logic [TOL_W-1:0]    tolerance_low;
    logic [TOL_W-1:0]    tolerance_high;
  } cfg_t;

endpackage

// ----- rtl/core/ckpb_chroma.sv -----
// Chroma front end: Cb/Cr numerators, divide by one million, squared key distance.
module ckpb_chroma import ckpb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  input  pix_in_t         in_pix_i,
  output logic            out_valid_o,
  output logic [SQ_W-1:0] out_sq_o,
  output pix_in_t         out_pix_o
);

  logic signed [PROD_W-1:0] r_s, g_s, b_s;
  logic signed [PROD_W-1:0] cb_num_s, cr_num_s;
  logic [NUM_W-1:0]         cb_num_d, cr_num_d;
  logic [NUM_W-1:0]         cb_num_q, cr_num_q;
  logic [NUM_W+RECIP_W-1:0] cb_prod, cr_prod;
  logic [CHROMA_W-1:0]      cb_d, cr_d, cb_q, cr_q;
  logic signed [DIFF_W-1:0] dcb, dcr;
  logic signed [2*DIFF_W-1:0] dcb_sq, dcr_sq;
  logic [SQ_W-1:0]          sq_d, sq_q;
  logic                     v1_q, v2_q, v3_q;
  pix_in_t                  p1_q, p2_q, p3_q;

  always_comb begin
    r_s = $signed(PROD_W'(in_pix_i.fg_red));
    g_s = $signed(PROD_W'(in_pix_i.fg_green));
    b_s = $signed(PROD_W'(in_pix_i.fg_blue));
    cb_num_s = 30'sd128500000 - 30'sd168736 * r_s - 30'sd331264 * g_s + 30'sd500000 * b_s;
    cr_num_s = 30'sd128500000 + 30'sd500000 * r_s - 30'sd418688 * g_s - 30'sd81312 * b_s;
    cb_num_d = cb_num_s[PROD_W-1] ? '0 : cb_num_s[NUM_W-1:0];
    cr_num_d = cr_num_s[PROD_W-1] ? '0 : cr_num_s[NUM_W-1:0];
  end

  always_comb begin
    cb_prod = (NUM_W+RECIP_W)'(cb_num_q) * (NUM_W+RECIP_W)'(RECIP_1E6);
    cr_prod = (NUM_W+RECIP_W)'(cr_num_q) * (NUM_W+RECIP_W)'(RECIP_1E6);
    cb_d = cb_prod[RECIP_SHIFT +: CHROMA_W];
    cr_d = cr_prod[RECIP_SHIFT +: CHROMA_W];
  end

  always_comb begin
    dcb = $signed({1'b0, cb_q}) - $signed({1'b0, cfg_i.key_blue_chroma});
    dcr = $signed({1'b0, cr_q}) - $signed({1'b0, cfg_i.key_red_chroma});
    dcb_sq = dcb * dcb;
    dcr_sq = dcr * dcr;
    sq_d = SQ_W'(dcb_sq[SQ_W-2:0]) + SQ_W'(dcr_sq[SQ_W-2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cb_num_q <= cb_num_d;
      cr_num_q <= cr_num_d;
      p1_q     <= in_pix_i;
      cb_q     <= cb_d;
      cr_q     <= cr_d;
      p2_q     <= p1_q;
      sq_q     <= sq_d;
      p3_q     <= p2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_sq_o    = sq_q;
  assign out_pix_o   = p3_q;

endmodule

// ----- rtl/core/ckpb_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage.
module ckpb_sqrt import ckpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [SQ_W-1:0]   in_sq_i,
  input  pix_in_t           in_pix_i,
  output logic              out_valid_o,
  output logic [ROOT_W-1:0] out_root_o,
  output logic [REM_W-1:0]  out_rem_o,
  output pix_in_t           out_pix_o
);

  logic                 valid_q [ROOT_W];
  logic [RAD_PAD_W-1:0] rad_q   [ROOT_W];
  logic [REM_W-1:0]     rem_q   [ROOT_W];
  logic [ROOT_W-1:0]    root_q  [ROOT_W];
  pix_in_t              pix_q   [ROOT_W];

  logic [RAD_PAD_W-1:0] rad_in;

  assign rad_in = RAD_PAD_W'(in_sq_i) << (2 * FRAC_BITS);

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                 valid_prev;
    logic [RAD_PAD_W-1:0] rad_prev;
    logic [REM_W-1:0]     rem_prev;
    logic [ROOT_W-1:0]    root_prev;
    pix_in_t              pix_prev;
    logic [REM_W-1:0]     rem_sh, trial, rem_d;
    logic [ROOT_W-1:0]    root_d;
    logic                 ge;

    if (k == 0) begin : g_first
      assign valid_prev = in_valid_i;
      assign rad_prev   = rad_in;
      assign rem_prev   = '0;
      assign root_prev  = '0;
      assign pix_prev   = in_pix_i;
    end else begin : g_next
      assign valid_prev = valid_q[k-1];
      assign rad_prev   = rad_q[k-1];
      assign rem_prev   = rem_q[k-1];
      assign root_prev  = root_q[k-1];
      assign pix_prev   = pix_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_prev[REM_W-3:0], rad_prev[2*(ROOT_W-1-k) +: 2]};
      trial  = {root_prev, 2'b01};
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_prev[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_prev;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        pix_q[k]  <= pix_prev;
      end
    end
  end

  assign out_valid_o = valid_q[ROOT_W-1];
  assign out_root_o  = root_q[ROOT_W-1];
  assign out_rem_o   = rem_q[ROOT_W-1];
  assign out_pix_o   = pix_q[ROOT_W-1];

endmodule

// ----- rtl/core/ckpb_keep.sv -----
// Keep weight: distance rounding, tolerance compare and pipelined ramp divider.
module ckpb_keep import ckpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  input  logic [ROOT_W-1:0] in_root_i,
  input  logic [REM_W-1:0]  in_rem_i,
  input  pix_in_t           in_pix_i,
  output logic              out_valid_o,
  output logic [KEEP_W-1:0] out_keep_o,
  output pix_in_t           out_pix_o
);

  logic [DIST_W-1:0] dist_d, dist_q;
  logic              dv_q;
  pix_in_t           dp_q;

  logic [CMP_W-1:0]  dist_ext, tl_ext, th_ext, num_ext;
  keep_mode_e        mode_d, mode_q;
  logic [TOL_W-1:0]  num_d, num_q;
  logic              cv_q;
  pix_in_t           cp_q;
  logic [TOL_W-1:0]  den_q;

  logic              valid_q [QUOT_W];
  keep_mode_e        dmode_q [QUOT_W];
  logic [TOL_W-1:0]  rem_q   [QUOT_W];
  logic [QUOT_W-1:0] quot_q  [QUOT_W];
  pix_in_t           pix_q   [QUOT_W];

  assign dist_d = in_root_i + DIST_W'(in_rem_i > REM_W'(in_root_i));

  always_comb begin
    dist_ext = CMP_W'(dist_q);
    tl_ext   = CMP_W'(cfg_i.tolerance_low);
    th_ext   = CMP_W'(cfg_i.tolerance_high);
    num_ext  = dist_ext - tl_ext;
    num_d    = num_ext[TOL_W-1:0];
    priority if (dist_ext < tl_ext) begin
      mode_d = KEEP_ZERO;
    end else if (dist_ext < th_ext) begin
      mode_d = KEEP_RAMP;
    end else begin
      mode_d = KEEP_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
      cv_q <= 1'b0;
    end else if (en_i) begin
      dv_q <= in_valid_i;
      cv_q <= dv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= cfg_i.tolerance_high - cfg_i.tolerance_low;
    if (en_i) begin
      dist_q <= dist_d;
      dp_q   <= in_pix_i;
      mode_q <= mode_d;
      num_q  <= num_d;
      cp_q   <= dp_q;
    end
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    logic              valid_prev;
    keep_mode_e        mode_prev;
    logic [TOL_W-1:0]  rem_prev;
    logic [QUOT_W-1:0] quot_prev;
    pix_in_t           pix_prev;
    logic [TOL_W:0]    rem_sh;
    logic              ge;
    logic [TOL_W-1:0]  rem_d;
    logic [QUOT_W-1:0] quot_d;

    if (k == 0) begin : g_first
      assign valid_prev = cv_q;
      assign mode_prev  = mode_q;
      assign rem_prev   = num_q;
      assign quot_prev  = '0;
      assign pix_prev   = cp_q;
    end else begin : g_next
      assign valid_prev = valid_q[k-1];
      assign mode_prev  = dmode_q[k-1];
      assign rem_prev   = rem_q[k-1];
      assign quot_prev  = quot_q[k-1];
      assign pix_prev   = pix_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_prev, 1'b0};
      ge     = (rem_sh >= (TOL_W+1)'(den_q));
      rem_d  = ge ? TOL_W'(rem_sh - (TOL_W+1)'(den_q)) : rem_sh[TOL_W-1:0];
      quot_d = {quot_prev[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dmode_q[k] <= mode_prev;
        rem_q[k]   <= rem_d;
        quot_q[k]  <= quot_d;
        pix_q[k]   <= pix_prev;
      end
    end
  end

  always_comb begin
    unique case (dmode_q[QUOT_W-1])
      KEEP_ZERO: out_keep_o = '0;
      KEEP_RAMP: out_keep_o = {1'b0, quot_q[QUOT_W-1]};
      KEEP_FULL: out_keep_o = KEEP_ONE;
      default:   out_keep_o = '0;
    endcase
  end

  assign out_valid_o = valid_q[QUOT_W-1];
  assign out_pix_o   = pix_q[QUOT_W-1];

endmodule

// ----- rtl/core/ckpb_blend.sv -----
// Per-channel weighted blend of foreground and background into the output register.
module ckpb_blend import ckpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [KEEP_W-1:0] in_keep_i,
  input  pix_in_t           in_pix_i,
  output logic              out_valid_o,
  output pix_out_t          out_data_o
);

  localparam int unsigned MIX_W = KEEP_W + PIX_W;

  logic [KEEP_W-1:0] inv_keep;
  logic [MIX_W-1:0]  mix_r, mix_g, mix_b;
  pix_out_t          out_d, out_q;
  logic              out_valid_q;

  always_comb begin
    inv_keep = KEEP_ONE - in_keep_i;
    mix_r = MIX_W'(in_keep_i) * MIX_W'(in_pix_i.fg_red)
          + MIX_W'(inv_keep) * MIX_W'(in_pix_i.bg_red);
    mix_g = MIX_W'(in_keep_i) * MIX_W'(in_pix_i.fg_green)
          + MIX_W'(inv_keep) * MIX_W'(in_pix_i.bg_green);
    mix_b = MIX_W'(in_keep_i) * MIX_W'(in_pix_i.fg_blue)
          + MIX_W'(inv_keep) * MIX_W'(in_pix_i.bg_blue);
    out_d.out_red   = mix_r[QUOT_W +: PIX_W];
    out_d.out_green = mix_g[QUOT_W +: PIX_W];
    out_d.out_blue  = mix_b[QUOT_W +: PIX_W];
    out_d.out_last  = in_pix_i.last_pixel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/chroma_key_pixel_blend_unit.sv -----
// Top level of the chroma key pixel blend unit: config registers and pipeline.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------
//   in       | in_valid_i / in_ready_o    | in_data_i  (pix_in_t)
//   out      | out_valid_o / out_ready_i  | out_data_o (pix_out_t)
//   cfg      | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One request per cycle while the pipeline is not held; the square root and the
// ramp divider each resolve one bit per stage.
// The whole pipeline advances together; it holds only while the output
// register carries a result that is not taken, and bubbles move on freely.
// Reset clears the valid bits and sets all four registers to zero.
module chroma_key_pixel_blend_unit import ckpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              en;

  logic              ch_valid;
  logic [SQ_W-1:0]   ch_sq;
  pix_in_t           ch_pix;

  logic              sr_valid;
  logic [ROOT_W-1:0] sr_root;
  logic [REM_W-1:0]  sr_rem;
  pix_in_t           sr_pix;

  logic              kp_valid;
  logic [KEEP_W-1:0] kp_keep;
  pix_in_t           kp_pix;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_CB:   cfg_q.key_blue_chroma <= cfg_data_i[CHROMA_W-1:0];
        REG_KEY_CR:   cfg_q.key_red_chroma  <= cfg_data_i[CHROMA_W-1:0];
        REG_TOL_LOW:  cfg_q.tolerance_low   <= cfg_data_i[TOL_W-1:0];
        REG_TOL_HIGH: cfg_q.tolerance_high  <= cfg_data_i[TOL_W-1:0];
      endcase
    end
  end

  ckpb_chroma u_chroma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_pix_i    (in_data_i),
    .out_valid_o (ch_valid),
    .out_sq_o    (ch_sq),
    .out_pix_o   (ch_pix)
  );

  ckpb_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (ch_valid),
    .in_sq_i     (ch_sq),
    .in_pix_i    (ch_pix),
    .out_valid_o (sr_valid),
    .out_root_o  (sr_root),
    .out_rem_o   (sr_rem),
    .out_pix_o   (sr_pix)
  );

  ckpb_keep u_keep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .in_valid_i  (sr_valid),
    .in_root_i   (sr_root),
    .in_rem_i    (sr_rem),
    .in_pix_i    (sr_pix),
    .out_valid_o (kp_valid),
    .out_keep_o  (kp_keep),
    .out_pix_o   (kp_pix)
  );

  ckpb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (kp_valid),
    .in_keep_i   (kp_keep),
    .in_pix_i    (kp_pix),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- verif/chroma_key_pixel_blend_unit_test.sv -----
// Self-checking testbench of the chroma key pixel blend unit: directed table, then random phases.
`timescale 1ns / 100ps

module chroma_key_pixel_blend_unit_test;
  import ckpb_pkg::*;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] key_cb;
    logic [CFG_DATA_W-1:0] key_cr;
    logic [CFG_DATA_W-1:0] tol_lo;
    logic [CFG_DATA_W-1:0] tol_hi;
  } reg_words_t;

  typedef struct {
    int          setting;
    logic [23:0] fg;
    logic [23:0] bg;
    logic        last;
    bit          typed;
    logic [23:0] rgb;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pix_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  pix_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [CHROMA_W-1:0] key_cb_w;
  logic [CHROMA_W-1:0] key_cr_w;
  logic [TOL_W-1:0]    tol_lo_w;
  logic [TOL_W-1:0]    tol_hi_w;

  pix_out_t expected_pixels[$];
  int       fail_cnt;
  int       send_idle_pct;
  int       recv_stall_pct;

  reg_words_t directed_words [4] = '{
    '{13'h0000, 13'h0000, 13'h0000, 13'h0000},
    '{13'h1F00, 13'h1F00, 13'h1FFF, 13'h0000},
    '{13'h01FF, 13'h01FF, 13'h0AAA, 13'h1555},
    '{13'h0080, 13'h0080, 13'd3000, 13'd3000}
  };

  plan_row_t plan [24] = '{
    '{0, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1, 24'h000000},
    '{0, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1, 24'hFFFFFF},
    '{0, 24'hFF0000, 24'h00FF00, 1'b0, 1'b1, 24'hFF0000},
    '{0, 24'h00FF00, 24'h0000FF, 1'b1, 1'b1, 24'h00FF00},
    '{0, 24'h0000FF, 24'hFF0000, 1'b0, 1'b1, 24'h0000FF},
    '{0, 24'h808080, 24'h7F7F7F, 1'b0, 1'b1, 24'h808080},
    '{0, 24'h55AA55, 24'hAA55AA, 1'b1, 1'b1, 24'h55AA55},
    '{0, 24'h01FE80, 24'hFE0172, 1'b0, 1'b1, 24'h01FE80},
    '{1, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
    '{1, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1, 24'h000000},
    '{1, 24'h0000FF, 24'h123456, 1'b0, 1'b1, 24'h123456},
    '{1, 24'hFF0000, 24'hA5C3E1, 1'b1, 1'b1, 24'hA5C3E1},
    '{1, 24'h00FF00, 24'h5A3C1E, 1'b0, 1'b1, 24'h5A3C1E},
    '{1, 24'h808080, 24'h808080, 1'b1, 1'b1, 24'h808080},
    '{2, 24'h0000FF, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{2, 24'hFF0000, 24'hFFFFFF, 1'b1, 1'b0, 24'h000000},
    '{2, 24'h000000, 24'h80FF00, 1'b0, 1'b0, 24'h000000},
    '{2, 24'hFFFFFF, 24'h00807F, 1'b1, 1'b0, 24'h000000},
    '{2, 24'h00FF00, 24'hFF00FF, 1'b0, 1'b0, 24'h000000},
    '{3, 24'h808080, 24'h112233, 1'b0, 1'b0, 24'h000000},
    '{3, 24'hFF0000, 24'h445566, 1'b1, 1'b0, 24'h000000},
    '{3, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
    '{3, 24'h0000FF, 24'h000000, 1'b1, 1'b0, 24'h000000},
    '{3, 24'h7F8081, 24'h0A0B0C, 1'b0, 1'b0, 24'h000000}
  };

  chroma_key_pixel_blend_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pix_out_t blend_pixel(pix_in_t p);
    longint   r, g, b, cb, cr, dcb, dcr, rad, root, trial, dist_fx, keep;
    pix_out_t o;
    r = p.fg_red;
    g = p.fg_green;
    b = p.fg_blue;
    cb = 128500000 - 168736 * r - 331264 * g + 500000 * b;
    cr = 128500000 + 500000 * r - 418688 * g - 81312 * b;
    cb = (cb < 0) ? 0 : cb / 1000000;
    cr = (cr < 0) ? 0 : cr / 1000000;
    dcb = cb - longint'(key_cb_w);
    dcr = cr - longint'(key_cr_w);
    rad = (dcb * dcb + dcr * dcr) << (2 * FRAC_BITS);
    root = 0;
    for (int k = 24; k >= 0; k--) begin
      trial = root + (longint'(1) << k);
      if (trial * trial <= rad) root = trial;
    end
    dist_fx = root + ((rad > root * root + root) ? 1 : 0);
    if (dist_fx < longint'(tol_lo_w)) keep = 0;
    else if (dist_fx < longint'(tol_hi_w))
      keep = ((dist_fx - longint'(tol_lo_w)) << 8) / (longint'(tol_hi_w) - longint'(tol_lo_w));
    else keep = 256;
    o.out_red   = 8'((keep * r + (256 - keep) * longint'(p.bg_red)) >> 8);
    o.out_green = 8'((keep * g + (256 - keep) * longint'(p.bg_green)) >> 8);
    o.out_blue  = 8'((keep * b + (256 - keep) * longint'(p.bg_blue)) >> 8);
    o.out_last  = p.last_pixel;
    return o;
  endfunction

  function automatic reg_words_t draw_setting();
    reg_words_t s;
    int         sel;
    logic [12:0] a, c;
    s.key_cb = 13'($urandom);
    s.key_cr = 13'($urandom);
    sel = $urandom_range(9);
    if (sel == 0) s.key_cb[8:0] = 9'd0;
    else if (sel == 1) s.key_cb[8:0] = 9'd256;
    else if (sel != 2) s.key_cb[8:0] = 9'($urandom_range(256));
    sel = $urandom_range(9);
    if (sel == 0) s.key_cr[8:0] = 9'd0;
    else if (sel == 1) s.key_cr[8:0] = 9'd256;
    else if (sel != 2) s.key_cr[8:0] = 9'($urandom_range(256));
    a = 13'($urandom_range(5793));
    c = 13'($urandom_range(5793));
    case ($urandom_range(7))
      0: begin s.tol_lo = 13'd0; s.tol_hi = 13'd5793; end
      1: begin s.tol_lo = (a > c) ? a : c; s.tol_hi = (a > c) ? c : a; end
      2: begin s.tol_lo = a; s.tol_hi = a; end
      3: begin s.tol_lo = 13'($urandom); s.tol_hi = 13'($urandom); end
      4: begin s.tol_lo = 13'd0; s.tol_hi = 13'h1FFF; end
      default: begin s.tol_lo = (a < c) ? a : c; s.tol_hi = (a < c) ? c : a; end
    endcase
    return s;
  endfunction

  function automatic pix_in_t draw_pixel();
    pix_in_t p;
    p = 49'({$urandom, $urandom});
    if ($urandom_range(4) == 0) begin
      p.fg_green = p.fg_red;
      p.fg_blue  = p.fg_red;
    end
    return p;
  endfunction

  task automatic push_pixel(input pix_in_t p, input bit typed, input pix_out_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(typed ? typed_res : blend_pixel(p));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input reg_words_t s);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_KEY_CB;
    cfg_data <= s.key_cb;
    @(posedge clk);
    cfg_idx  <= REG_KEY_CR;
    cfg_data <= s.key_cr;
    @(posedge clk);
    cfg_idx  <= REG_TOL_LOW;
    cfg_data <= s.tol_lo;
    @(posedge clk);
    cfg_idx  <= REG_TOL_HIGH;
    cfg_data <= s.tol_hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    key_cb_w = s.key_cb[CHROMA_W-1:0];
    key_cr_w = s.key_cr[CHROMA_W-1:0];
    tol_lo_w = s.tol_lo[TOL_W-1:0];
    tol_hi_w = s.tol_hi[TOL_W-1:0];
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    pix_out_t got;
    pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (expected_pixels.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
            got.out_blue !== want.out_blue || got.out_last !== want.out_last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: expected rgb %h %h %h last %b, got rgb %h %h %h last %b",
                     want.out_red, want.out_green, want.out_blue, want.out_last,
                     got.out_red, got.out_green, got.out_blue, got.out_last);
        end
      end
    end
  end

  initial begin
    int cur;
    fail_cnt       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    key_cb_w = '0;
    key_cr_w = '0;
    tol_lo_w = '0;
    tol_hi_w = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_KEY_CB;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = 0;
    foreach (plan[i]) begin
      if (plan[i].setting != cur) begin
        settle();
        cur = plan[i].setting;
        load_setting(directed_words[cur]);
      end
      push_pixel({plan[i].fg, plan[i].bg, plan[i].last}, plan[i].typed,
                 {plan[i].rgb, plan[i].last});
    end

    for (int phase = 0; phase < 16; phase++) begin
      settle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      load_setting(draw_setting());
      repeat (100) push_pixel(draw_pixel(), 1'b0, '0);
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && expected_pixels.size() == 0) begin
      $display("PASS chroma_key_pixel_blend_unit");
    end else begin
      $display("FAIL chroma_key_pixel_blend_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL chroma_key_pixel_blend_unit");
    $finish;
  end

endmodule
